// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// types, widths and operation codes of the green conflict monitor
// ----------------------------------------------------------------------------
`default_nettype none

package gcm_pkg;

    localparam int GROUPS      = 16;
    localparam int GRP_W       = $clog2(GROUPS);
    localparam int OP_W        = 3;
    localparam int GRP_FIELD_W = 6;
    localparam int VAL_W       = 2;
    localparam int RES_W       = 2;

    localparam logic [OP_W-1:0] OP_SET_CONFLICT   = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY_CONFLICT = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_OUTPUT     = 3'd2;
    localparam logic [OP_W-1:0] OP_GET_OUTPUT     = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK_PHASE    = 3'd4;

    typedef logic [GRP_W-1:0]  grp_idx_t;
    typedef logic [GROUPS-1:0] row_t;
    typedef logic [VAL_W-1:0]  level_t;

    // write request into the stores
    typedef struct packed {
        logic     row_we;
        grp_idx_t row_addr;
        grp_idx_t bit_addr;
        logic     bit_val;
        logic     lvl_we;
        grp_idx_t lvl_addr;
        level_t   lvl_val;
    } gcm_wr_t;

endpackage

`default_nettype wire

// File: rtl/gcm_if.sv
// ----------------------------------------------------------------------------
// gcm_if
// request and response channels of the green conflict monitor
// ----------------------------------------------------------------------------
`default_nettype none

interface gcm_in_if;
    logic                               valid;
    logic                               ready;
    logic [gcm_pkg::OP_W-1:0]           operation;
    logic [gcm_pkg::GRP_FIELD_W-1:0]    first_group;
    logic [gcm_pkg::GRP_FIELD_W-1:0]    second_group;
    logic [gcm_pkg::VAL_W-1:0]          value;

    modport source (output valid, operation, first_group, second_group, value,
                    input ready);
    modport sink   (input valid, operation, first_group, second_group, value,
                    output ready);
endinterface

interface gcm_out_if;
    logic                       valid;
    logic                       ready;
    logic [gcm_pkg::RES_W-1:0]  result;
    logic                       out_of_range;

    modport source (output valid, result, out_of_range, input ready);
    modport sink   (input valid, result, out_of_range, output ready);
endinterface

`default_nettype wire

// File: rtl/gcm_store.sv
// ----------------------------------------------------------------------------
// gcm_store
// conflict rows (one row per higher group) and per-group output levels
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gcm_pkg::gcm_wr_t  wr,
    input  wire gcm_pkg::grp_idx_t row_rd_addr,
    output gcm_pkg::row_t          row_rd_data,
    input  wire gcm_pkg::grp_idx_t lvl_rd_addr,
    output gcm_pkg::level_t        lvl_rd_data,
    output gcm_pkg::row_t          lit_mask
);

    // row hi, bit lo marks a conflict between zero-based groups lo < hi
    gcm_pkg::row_t   rows_reg   [gcm_pkg::GROUPS];
    gcm_pkg::level_t levels_reg [gcm_pkg::GROUPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcm_pkg::GROUPS; i++)
            begin
                rows_reg[i]   <= '0;
                levels_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.row_we)
            begin
                rows_reg[wr.row_addr][wr.bit_addr] <= wr.bit_val;
            end
            if (wr.lvl_we)
            begin
                levels_reg[wr.lvl_addr] <= wr.lvl_val;
            end
        end
    end

    assign row_rd_data = rows_reg[row_rd_addr];
    assign lvl_rd_data = levels_reg[lvl_rd_addr];

    always_comb
    begin
        for (int i = 0; i < gcm_pkg::GROUPS; i++)
        begin
            lit_mask[i] = |levels_reg[i];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gcm_scan.sv
// ----------------------------------------------------------------------------
// gcm_scan
// row compare unit: one conflict row against the lit groups per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_scan (
    input  wire gcm_pkg::row_t     row,
    input  wire gcm_pkg::row_t     lit_mask,
    input  wire gcm_pkg::grp_idx_t row_idx,
    output logic                   hit
);

    // lit group row_idx conflicts with some lit lower group
    assign hit = lit_mask[row_idx] & (|(row & lit_mask));

endmodule

`default_nettype wire

// File: rtl/green_conflict_monitor_top.sv
// ----------------------------------------------------------------------------
// green_conflict_monitor_top
// green conflict table and lamp group output levels with phase check
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                        handshake
//  in_ch    sink       operation, first_group, second_group, value    valid/ready
//  out_ch   source     result, out_of_range                           valid/ready
//
//  conflict and output accesses go from accept through the execute and done
//  states; a phase check adds a scan state, one conflict row per cycle through
//  the row compare unit from row 1 to row GROUPS-1, stopping at the first hit
//  in_ch.ready is high only while the sequencer is idle; a result waiting in
//  the output register does not block the next request
//  rst_n clears both stores and all control state asynchronously
//  a stalled output holds the sequencer in its done state until taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module green_conflict_monitor_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gcm_in_if.sink     in_ch,
    gcm_out_if.source  out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [gcm_pkg::OP_W-1:0]        op_reg, op_next;
    logic [gcm_pkg::GRP_FIELD_W-1:0] g1_reg, g1_next;
    logic [gcm_pkg::GRP_FIELD_W-1:0] g2_reg, g2_next;
    logic [gcm_pkg::VAL_W-1:0]       val_reg, val_next;

    // pending result and scan position
    logic [gcm_pkg::RES_W-1:0]       res_reg, res_next;
    logic                            oor_reg, oor_next;
    gcm_pkg::grp_idx_t               scan_cnt_reg, scan_cnt_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [gcm_pkg::RES_W-1:0]       out_res_reg, out_res_next;
    logic                            out_oor_reg, out_oor_next;

    // decode of the latched request
    logic              g1_ok, g2_ok;
    gcm_pkg::grp_idx_t a_idx, b_idx, hi_idx, lo_idx;
    logic              same_group;

    gcm_pkg::gcm_wr_t  wr;
    gcm_pkg::grp_idx_t row_rd_addr;
    gcm_pkg::row_t     row_rd_data;
    gcm_pkg::level_t   lvl_rd_data;
    gcm_pkg::row_t     lit_mask;
    logic              scan_hit;
    logic              in_accept;
    logic              out_free;

    assign g1_ok = (g1_reg != '0) &&
                   (g1_reg <= gcm_pkg::GRP_FIELD_W'(gcm_pkg::GROUPS));
    assign g2_ok = (g2_reg != '0) &&
                   (g2_reg <= gcm_pkg::GRP_FIELD_W'(gcm_pkg::GROUPS));

    // zero-based group numbers, valid only when in range
    assign a_idx      = gcm_pkg::GRP_W'(g1_reg - gcm_pkg::GRP_FIELD_W'(1));
    assign b_idx      = gcm_pkg::GRP_W'(g2_reg - gcm_pkg::GRP_FIELD_W'(1));
    assign hi_idx     = (a_idx > b_idx) ? a_idx : b_idx;
    assign lo_idx     = (a_idx > b_idx) ? b_idx : a_idx;
    assign same_group = (g1_reg == g2_reg);

    // store writes happen once, in the execute cycle
    always_comb
    begin
        wr.row_we   = (state_reg == ST_EXEC) && (op_reg == gcm_pkg::OP_SET_CONFLICT) &&
                      g1_ok && g2_ok && !same_group;
        wr.row_addr = hi_idx;
        wr.bit_addr = lo_idx;
        wr.bit_val  = (val_reg != '0);
        wr.lvl_we   = (state_reg == ST_EXEC) && (op_reg == gcm_pkg::OP_SET_OUTPUT) && g1_ok;
        wr.lvl_addr = a_idx;
        wr.lvl_val  = val_reg;
    end

    // single row read port, shared by query and phase scan
    assign row_rd_addr = (state_reg == ST_SCAN) ? scan_cnt_reg : hi_idx;

    gcm_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .row_rd_addr (row_rd_addr),
        .row_rd_data (row_rd_data),
        .lvl_rd_addr (a_idx),
        .lvl_rd_data (lvl_rd_data),
        .lit_mask    (lit_mask)
    );

    gcm_scan u_scan (
        .row      (row_rd_data),
        .lit_mask (lit_mask),
        .row_idx  (scan_cnt_reg),
        .hit      (scan_hit)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        oor_next       = oor_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_oor_next   = out_oor_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = in_ch.operation;
                    g1_next    = in_ch.first_group;
                    g2_next    = in_ch.second_group;
                    val_next   = in_ch.value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next   = '0;
                oor_next   = 1'b0;
                state_next = ST_DONE;
                unique case (op_reg)
                    gcm_pkg::OP_SET_CONFLICT:
                    begin
                        oor_next = !(g1_ok && g2_ok);
                    end
                    gcm_pkg::OP_QUERY_CONFLICT:
                    begin
                        oor_next = !(g1_ok && g2_ok);
                        if (g1_ok && g2_ok && !same_group)
                        begin
                            res_next = {1'b0, row_rd_data[lo_idx]};
                        end
                    end
                    gcm_pkg::OP_SET_OUTPUT:
                    begin
                        oor_next = !g1_ok;
                    end
                    gcm_pkg::OP_GET_OUTPUT:
                    begin
                        oor_next = !g1_ok;
                        if (g1_ok)
                        begin
                            res_next = lvl_rd_data;
                        end
                    end
                    gcm_pkg::OP_CHECK_PHASE:
                    begin
                        // row 0 has no lower groups, start at row 1
                        scan_cnt_next = gcm_pkg::GRP_W'(1);
                        state_next    = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_hit || (scan_cnt_reg == gcm_pkg::GRP_W'(gcm_pkg::GROUPS - 1)))
                begin
                    res_next   = {1'b0, scan_hit};
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + gcm_pkg::GRP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        g1_reg      <= g1_next;
        g2_reg      <= g2_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        oor_reg     <= oor_next;
        out_res_reg <= out_res_next;
        out_oor_reg <= out_oor_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result       = out_res_reg;
    assign out_ch.out_of_range = out_oor_reg;

    // busy right after a request is taken
    `ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ch.ready)
    // scan never visits row 0 or runs past the last row
    `ASSERT_SAME(a_scan_range, state_reg == ST_SCAN,
                 (scan_cnt_reg != '0) &&
                 (scan_cnt_reg <= gcm_pkg::GRP_W'(gcm_pkg::GROUPS - 1)))
    // a new result only comes out of the done state
    `ASSERT_SAME(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    // stores change only in the execute cycle
    `ASSERT_SAME(a_write_in_exec, wr.row_we || wr.lvl_we, state_reg == ST_EXEC)

endmodule

`default_nettype wire

// File: bench/tb_green_conflict_monitor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_answer_checker
// watches both channels of the green conflict monitor, predicts the answer
// of every accepted request and compares it with the returned response
// ----------------------------------------------------------------------------

module gcm_answer_checker
    import gcm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    gcm_in_if         in_ch,
    gcm_out_if        out_ch,
    output int        fail_count,
    output int        waiting
);

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             out_of_range;
    } answer_t;

    // conflict_map[lo][hi] with zero-based lo < hi
    bit         conflict_map [GROUPS][GROUPS];
    level_t     lamp_level   [GROUPS];
    answer_t    pending_answers [$];
    int         errors  = 0;
    int         backlog = 0;

    assign fail_count = errors;
    assign waiting    = backlog;

    initial
    begin
        foreach (conflict_map[i, j])
            conflict_map[i][j] = 1'b0;
        foreach (lamp_level[i])
            lamp_level[i] = '0;
    end

    function automatic bit group_valid(logic [GRP_FIELD_W-1:0] g);
        return g >= 1 && g <= GROUPS;
    endfunction

    // updates the shadow stores and returns the answer due for one request
    function automatic answer_t predict_answer(
        logic [OP_W-1:0]        op,
        logic [GRP_FIELD_W-1:0] g1,
        logic [GRP_FIELD_W-1:0] g2,
        logic [VAL_W-1:0]       val
    );
        answer_t ans;
        int      lo;
        int      hi;
        ans = '0;
        case (op)
            OP_SET_CONFLICT, OP_QUERY_CONFLICT:
            begin
                if (!group_valid(g1) || !group_valid(g2))
                    ans.out_of_range = 1'b1;
                else if (g1 != g2)
                begin
                    lo = ((g1 < g2) ? g1 : g2) - 1;
                    hi = ((g1 < g2) ? g2 : g1) - 1;
                    if (op == OP_SET_CONFLICT)
                        conflict_map[lo][hi] = (val != 0);
                    else
                        ans.result = {1'b0, conflict_map[lo][hi]};
                end
            end
            OP_SET_OUTPUT:
            begin
                if (!group_valid(g1))
                    ans.out_of_range = 1'b1;
                else
                    lamp_level[g1 - 1] = val;
            end
            OP_GET_OUTPUT:
            begin
                if (!group_valid(g1))
                    ans.out_of_range = 1'b1;
                else
                    ans.result = lamp_level[g1 - 1];
            end
            OP_CHECK_PHASE:
            begin
                for (int i = 0; i < GROUPS; i++)
                    for (int j = i + 1; j < GROUPS; j++)
                        if (lamp_level[i] != 0 && lamp_level[j] != 0 && conflict_map[i][j])
                            ans.result = RES_W'(1);
            end
            default:
                ans = '0;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin : watch
        answer_t due;
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                pending_answers.push_back(predict_answer(in_ch.operation, in_ch.first_group,
                                                         in_ch.second_group, in_ch.value));
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: response with no request waiting, result %0d range %0d",
                             $time, out_ch.result, out_ch.out_of_range);
                    errors++;
                end
                else
                begin
                    due = pending_answers.pop_front();
                    if (out_ch.result !== due.result)
                    begin
                        $display("%0t: result mismatch, expected %0d, actual %0d",
                                 $time, due.result, out_ch.result);
                        errors++;
                    end
                    if (out_ch.out_of_range !== due.out_of_range)
                    begin
                        $display("%0t: out_of_range mismatch, expected %0d, actual %0d",
                                 $time, due.out_of_range, out_ch.out_of_range);
                        errors++;
                    end
                end
            end
            backlog = pending_answers.size();
        end
    end

endmodule

// File: bench/tb_green_conflict_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_green_conflict_monitor_top
// drives requests into the green conflict monitor with random gaps and
// response stalls; a separate checker predicts and compares every response
// ----------------------------------------------------------------------------

module tb_green_conflict_monitor_top;

    import gcm_pkg::*;

    // operation codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int RANDOM_CHUNKS = 8;
    localparam int CHUNK_ITEMS   = 122;
    localparam int MAX_GAP       = 16;

    localparam logic [GRP_FIELD_W-1:0] G_LAST = GRP_FIELD_W'(GROUPS);
    localparam logic [GRP_FIELD_W-1:0] G_OVER = GRP_FIELD_W'(GROUPS + 1);

    logic clk;
    logic rst_n;
    bit   quiet;       // when set, neither side idles
    int   fail_count;
    int   waiting;

    gcm_in_if  req_ch ();
    gcm_out_if rsp_ch ();

    green_conflict_monitor_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    gcm_answer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (req_ch),
        .out_ch     (rsp_ch),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("tb_green_conflict_monitor_top failed");
        $finish;
    end

    // one request: optional idle gap, then hold valid until the block takes it;
    // entered and left at a falling edge
    task automatic send_request(
        input logic [OP_W-1:0]        op,
        input logic [GRP_FIELD_W-1:0] g1,
        input logic [GRP_FIELD_W-1:0] g2,
        input logic [VAL_W-1:0]       val
    );
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.operation    <= op;
        req_ch.first_group  <= g1;
        req_ch.second_group <= g2;
        req_ch.value        <= val;
        req_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // mostly a legal group, now and then anything the 6-bit field can hold
    function automatic logic [GRP_FIELD_W-1:0] pick_group();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return GRP_FIELD_W'($urandom_range(1, GROUPS));
        else if (r < 93)
            return '0;
        else if (r < 96)
            return G_OVER;
        else
            return GRP_FIELD_W'($urandom_range(0, (1 << GRP_FIELD_W) - 1));
    endfunction

    // one random request with a mix weighted toward realistic controller traffic
    task automatic send_random_request();
        logic [OP_W-1:0]        op;
        logic [GRP_FIELD_W-1:0] g1;
        logic [GRP_FIELD_W-1:0] g2;
        logic [VAL_W-1:0]       val;
        int                     r;
        r  = $urandom_range(0, 99);
        g1 = pick_group();
        g2 = ($urandom_range(0, 19) == 0) ? g1 : pick_group();
        if (r < 25)
        begin
            op  = OP_SET_CONFLICT;
            // keep the table sparse enough that a phase check can come out clean
            val = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(1, 3)) : '0;
        end
        else if (r < 40)
        begin
            op  = OP_QUERY_CONFLICT;
            val = VAL_W'($urandom_range(0, 3));
        end
        else if (r < 65)
        begin
            op  = OP_SET_OUTPUT;
            // few lit groups at a time, so the phase check sees both answers
            val = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom_range(1, 3)) : '0;
        end
        else if (r < 75)
        begin
            op  = OP_GET_OUTPUT;
            val = VAL_W'($urandom_range(0, 3));
        end
        else if (r < 95)
        begin
            op  = OP_CHECK_PHASE;
            val = VAL_W'($urandom_range(0, 3));
        end
        else
        begin
            op  = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            val = VAL_W'($urandom_range(0, 3));
        end
        send_request(op, g1, g2, val);
    endtask

    // response side: random stall before every response, none while quiet
    initial
    begin : response_taker
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
        end
    end

    initial
    begin : stimulus
        // all block inputs known from time zero
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_CHECK_PHASE;
        req_ch.first_group  <= '0;
        req_ch.second_group <= '0;
        req_ch.value        <= '0;
        quiet                = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed requests ----
        // empty tables: no conflict anywhere
        send_request(OP_CHECK_PHASE,    6'd0,    6'd0,    2'd0);
        send_request(OP_QUERY_CONFLICT, 6'd1,    6'd2,    2'd0);
        // extreme pair, written in one order and read in the other
        send_request(OP_SET_CONFLICT,   6'd1,    G_LAST,  2'd1);
        send_request(OP_QUERY_CONFLICT, G_LAST,  6'd1,    2'd0);
        // a group never conflicts with itself, neither on set nor on query
        send_request(OP_SET_CONFLICT,   6'd5,    6'd5,    2'd3);
        send_request(OP_QUERY_CONFLICT, 6'd5,    6'd5,    2'd0);
        // level 3 is stored as is and counts as lit
        send_request(OP_SET_OUTPUT,     6'd1,    6'd0,    2'd3);
        send_request(OP_GET_OUTPUT,     6'd1,    6'd0,    2'd0);
        send_request(OP_SET_OUTPUT,     G_LAST,  6'd63,   2'd1);
        send_request(OP_CHECK_PHASE,    6'd63,   6'd63,   2'd3);
        // clearing the pair removes the phase conflict
        send_request(OP_SET_CONFLICT,   G_LAST,  6'd1,    2'd0);
        send_request(OP_CHECK_PHASE,    6'd0,    6'd0,    2'd0);
        // group numbers outside the legal range on every access type
        send_request(OP_SET_CONFLICT,   6'd0,    6'd3,    2'd1);
        send_request(OP_QUERY_CONFLICT, G_OVER,  6'd2,    2'd0);
        send_request(OP_QUERY_CONFLICT, 6'd2,    6'd63,   2'd0);
        send_request(OP_SET_OUTPUT,     6'd0,    6'd1,    2'd2);
        send_request(OP_GET_OUTPUT,     6'd63,   6'd1,    2'd0);
        send_request(OP_SET_OUTPUT,     G_OVER,  6'd1,    2'd2);
        // second group is a don't-care for output accesses
        send_request(OP_GET_OUTPUT,     G_LAST,  6'd63,   2'd0);
        // unused operation codes
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_request(OP_W'(op), GRP_FIELD_W'($urandom_range(0, 63)),
                         GRP_FIELD_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 3)));
        // switch the lamps off again
        send_request(OP_SET_OUTPUT,     6'd1,    6'd0,    2'd0);
        send_request(OP_SET_OUTPUT,     G_LAST,  6'd0,    2'd0);

        // ---- random requests in chunks, every third one without idling ----
        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            quiet = (c % 3 == 1);
            // dark all lamps, light a couple and check the phase
            for (int g = 1; g <= GROUPS; g++)
                send_request(OP_SET_OUTPUT, GRP_FIELD_W'(g),
                             GRP_FIELD_W'($urandom_range(0, 63)), 2'd0);
            repeat (2)
                send_request(OP_SET_OUTPUT, GRP_FIELD_W'($urandom_range(1, GROUPS)),
                             GRP_FIELD_W'($urandom_range(0, 63)),
                             VAL_W'($urandom_range(1, 3)));
            send_request(OP_CHECK_PHASE, GRP_FIELD_W'($urandom_range(0, 63)),
                         GRP_FIELD_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 3)));
            repeat (CHUNK_ITEMS)
                send_random_request();
        end
        quiet = 1'b0;
        req_ch.valid <= 1'b0;

        // drain outstanding responses, then allow for a full phase check
        wait (waiting == 0);
        repeat (GROUPS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_green_conflict_monitor_top passed");
        else
            $display("tb_green_conflict_monitor_top failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/gcm_pkg.sv
rtl/gcm_if.sv
rtl/gcm_store.sv
rtl/gcm_scan.sv
rtl/green_conflict_monitor_top.sv
bench/tb_green_conflict_monitor_checker.sv
bench/tb_green_conflict_monitor_top.sv
